/* hw/rtl/fcf_pkg.sv */
// Package for the FAT12 cluster chain follower.
// Holds field widths, FAT12 constants and the result status codes.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fcf_pkg;

    // Field widths of the channels.
    localparam int OP_W        = 1;
    localparam int PAIR_W      = 11;
    localparam int PACKED_W    = 24;
    localparam int START_W     = 16;
    localparam int LENGTH_W    = 32;
    localparam int ATTR_W      = 8;
    localparam int COUNT_W     = 13;
    localparam int STATUS_W    = 3;
    localparam int LINK_W      = 12;
    localparam int CSIZE_W     = 21;
    localparam int COVERED_W   = 33;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OP_W-1:0] OP_FOLLOW = 1'b1;

    // FAT12 constants.
    localparam logic [LINK_W-1:0]  END_MARK       = 12'hFF0;
    localparam logic [ATTR_W-1:0]  LFN_ATTR       = 8'h0F;
    localparam int                 LABEL_BIT      = 3;
    localparam logic [CSIZE_W-1:0] CSIZE_RESET    = 21'd1024;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL = 3'd0,
        ST_BROKEN = 3'd1,
        ST_LFN    = 3'd2,
        ST_LABEL  = 3'd3,
        ST_BADSTART = 3'd4,
        ST_CAP    = 3'd5
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/fcf_if.sv */
// Channel interfaces of the FAT12 cluster chain follower: input items,
// results and the cluster size register write channel.
// Depends on fcf_pkg for the field widths.
`default_nettype none

interface fcf_item_if import fcf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [PAIR_W-1:0]   pair_index;
    logic [PACKED_W-1:0] packed_bytes;
    logic [START_W-1:0]  start_cluster;
    logic [LENGTH_W-1:0] file_length;
    logic [ATTR_W-1:0]   attributes;

    modport source (output valid, op, pair_index, packed_bytes, start_cluster,
                    file_length, attributes, input ready);
    modport sink   (input valid, op, pair_index, packed_bytes, start_cluster,
                    file_length, attributes, output ready);
endinterface

interface fcf_result_if import fcf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  cluster_count;
    logic [STATUS_W-1:0] status;
    logic [LINK_W-1:0]   last_link;

    modport source (output valid, cluster_count, status, last_link, input ready);
    modport sink   (input valid, cluster_count, status, last_link, output ready);
endinterface

interface fcf_cfg_if import fcf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CSIZE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fat12_chain_follower_top.sv */
// FAT12 cluster chain follower: link table memory and chain walker.
// Depends on fcf_pkg and the channel interfaces in fcf_if.sv.
//
// Usage notes.
// i_item carries one word per operation. A load word (op 0) writes three
// packed FAT bytes into the table row of its pair index; it gives no
// result. A follow word (op 1) checks the directory entry and walks the
// cluster chain; it gives exactly one result word on o_result.
// A follow is accepted in S_IDLE, then checked in S_START, which issues the
// first table read, then walked in S_WALK at one link per cycle, because the
// table has a single read port and each link read gives the address of the
// next; at most TABLE_ENTRIES links are read. A rejected entry or a finished
// walk waits in its state until the output register is free. i_item is not
// ready while a follow is in progress.
// Results sit in an output register, so loads and the next follow are taken
// while a result waits; if the receiver stalls, a finishing follow holds
// until the register is free.
// i_cfg writes the cluster size (bytes per cluster); it is always ready, and
// the user must write it only while the block is idle; the block does not
// enforce this. After reset the table is cleared row by row with i_item not
// ready; the cluster size resets to 1024.
`default_nettype none

module fat12_chain_follower_top
    import fcf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fcf_item_if.sink    i_item,
    fcf_result_if.source o_result,
    fcf_cfg_if.sink     i_cfg
);

    // Table geometry: one memory row holds an entry pair.
    localparam int ROWS = (TABLE_ENTRIES + 1) / 2;
    localparam int RAW  = $clog2(ROWS);
    localparam int CLW  = RAW + 1;
    localparam int CW   = $clog2(TABLE_ENTRIES + 1);

    localparam logic [CW-1:0]      ENTRIES_CW  = CW'(TABLE_ENTRIES);
    localparam logic [LINK_W:0]    ENTRIES_LK  = (LINK_W + 1)'(TABLE_ENTRIES);
    localparam logic [START_W-1:0] ENTRIES_ST  = START_W'(TABLE_ENTRIES);
    localparam logic [PAIR_W:0]    ROWS_PW     = (PAIR_W + 1)'(ROWS);
    localparam logic [RAW-1:0]     LAST_ROW    = RAW'(ROWS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_WALK
    } t_state;

    // Registers.
    t_state               r_state, n_state;
    logic [RAW-1:0]       r_clr_addr, n_clr_addr;
    logic [CSIZE_W-1:0]   r_cluster_size;
    logic [START_W-1:0]   r_start, n_start;
    logic [LENGTH_W-1:0]  r_length, n_length;
    logic [ATTR_W-1:0]    r_attr, n_attr;
    logic [CLW-1:0]       r_cluster, n_cluster;
    logic [CW-1:0]        r_count, n_count;
    logic [COVERED_W-1:0] r_covered, n_covered;
    logic                 r_half;
    logic                 r_out_valid, n_out_valid;
    logic [CW-1:0]        r_out_count, n_out_count;
    t_status              r_out_status, n_out_status;
    logic [LINK_W-1:0]    r_out_link, n_out_link;

    // Link table memory and its registered read word.
    logic [PACKED_W-1:0]  r_mem [ROWS];
    logic [PACKED_W-1:0]  r_rd;

    logic                 wr_en;
    logic [RAW-1:0]       wr_addr;
    logic [PACKED_W-1:0]  wr_data;
    logic                 rd_en;

    logic                 item_fire;
    logic                 out_free;
    logic [LINK_W-1:0]    next_link;
    logic [CSIZE_W-1:0]   step_size;
    logic [COVERED_W-1:0] cov_sum;
    logic                 cov_done;
    logic [CW-1:0]        count_inc;

    assign item_fire = i_item.valid && i_item.ready;
    assign out_free  = !r_out_valid || o_result.ready;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid         = r_out_valid;
    assign o_result.cluster_count = COUNT_W'(r_out_count);
    assign o_result.status        = r_out_status;
    assign o_result.last_link     = r_out_link;

    // The shared step unit: link selection, covered-bytes add and compare.
    assign next_link = r_half ? r_rd[2*LINK_W-1:LINK_W] : r_rd[LINK_W-1:0];
    assign step_size = (r_cluster_size == '0) ? CSIZE_W'(1) : r_cluster_size;
    assign cov_sum   = r_covered + COVERED_W'(step_size);
    assign cov_done  = cov_sum >= COVERED_W'(r_length);
    assign count_inc = r_count + CW'(1);

    // Memory write port: the clearing pass, then loads.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (item_fire && i_item.op == OP_LOAD
                     && ({1'b0, i_item.pair_index} < ROWS_PW)) begin
            wr_en   = 1'b1;
            wr_addr = i_item.pair_index[RAW-1:0];
            wr_data = i_item.packed_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd   <= r_mem[n_cluster[CLW-1:1]];
            r_half <= n_cluster[0];
        end
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_start      = r_start;
        n_length     = r_length;
        n_attr       = r_attr;
        n_cluster    = r_cluster;
        n_count      = r_count;
        n_covered    = r_covered;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        n_out_link   = r_out_link;
        rd_en        = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + RAW'(1);
                if (r_clr_addr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (item_fire && i_item.op == OP_FOLLOW) begin
                    n_start  = i_item.start_cluster;
                    n_length = i_item.file_length;
                    n_attr   = i_item.attributes;
                    n_state  = S_START;
                end
            end
            S_START: begin
                // Reject checks; otherwise read the first link.
                if (r_attr == LFN_ATTR || r_attr[LABEL_BIT]
                    || r_start < START_W'(2) || r_start >= ENTRIES_ST) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_count = '0;
                        n_out_link  = '0;
                        if (r_attr == LFN_ATTR) begin
                            n_out_status = ST_LFN;
                        end else if (r_attr[LABEL_BIT]) begin
                            n_out_status = ST_LABEL;
                        end else begin
                            n_out_status = ST_BADSTART;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    n_cluster = r_start[CLW-1:0];
                    n_count   = '0;
                    n_covered = '0;
                    rd_en     = 1'b1;
                    n_state   = S_WALK;
                end
            end
            S_WALK: begin
                // One link per cycle; a finished walk waits for the output.
                if (next_link == '0 || next_link >= END_MARK || cov_done
                    || {1'b0, next_link} >= ENTRIES_LK || count_inc >= ENTRIES_CW) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_count = count_inc;
                        n_out_link  = next_link;
                        if (next_link >= END_MARK) begin
                            n_out_status = ST_NORMAL;
                        end else if (next_link == '0 || cov_done
                                     || {1'b0, next_link} >= ENTRIES_LK) begin
                            n_out_status = ST_BROKEN;
                        end else begin
                            n_out_status = ST_CAP;
                        end
                        n_count   = count_inc;
                        n_covered = cov_sum;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_count   = count_inc;
                    n_covered = cov_sum;
                    n_cluster = next_link[CLW-1:0];
                    rd_en     = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_cluster_size <= CSIZE_RESET;
            r_cluster      <= '0;
            r_count        <= '0;
            r_covered      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cluster   <= n_cluster;
            r_count     <= n_count;
            r_covered   <= n_covered;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cluster_size <= i_cfg.data;
            end
        end
        r_start      <= n_start;
        r_length     <= n_length;
        r_attr       <= n_attr;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
        r_out_link   <= n_out_link;
    end

    // A walk in progress has never reached the step cap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_count < ENTRIES_CW))
    else $error("walk count passed the table depth");

    // A counted chain never exceeds the table depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= ENTRIES_CW))
    else $error("result count exceeds the table depth");

    // Rejected entries report no clusters and no link.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_LFN || r_out_status == ST_LABEL
                         || r_out_status == ST_BADSTART))
        |-> (r_out_count == '0 && r_out_link == '0))
    else $error("rejected entry with a count or link");

    // A walked chain counts at least one cluster.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_NORMAL || r_out_status == ST_BROKEN))
        |-> (r_out_count != '0))
    else $error("walked chain with zero clusters");

    // The step cap is reported only at exactly the table depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_CAP) |-> (r_out_count == ENTRIES_CW))
    else $error("step cap below the table depth");

    // The item channel is closed throughout the clearing pass.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!i_item.ready && !r_out_valid))
    else $error("item channel open during table clear");

endmodule

`default_nettype wire
